[rtl/lscp_pkg.sv]
`default_nettype none
package lscp_pkg;

  // operation codes
  localparam logic [2:0] OP_POSITION = 3'd0;
  localparam logic [2:0] OP_CALIB    = 3'd1;
  localparam logic [2:0] OP_RESTART  = 3'd2;
  localparam logic [2:0] OP_PRESET   = 3'd3;
  localparam logic [2:0] OP_CLRFLAG  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_FOLLOW_WHITE = 3'd0;
  localparam logic [2:0] CFG_STOP_INLINE  = 3'd1;
  localparam logic [2:0] CFG_FLAG_INLINE  = 3'd2;
  localparam logic [2:0] CFG_MIN_SPAN     = 3'd3;
  localparam logic [2:0] CFG_SCALE        = 3'd4;
  localparam logic [2:0] CFG_PRESET_BLACK = 3'd5;
  localparam logic [2:0] CFG_PRESET_WHITE = 3'd6;
  localparam logic [2:0] CFG_WHITE_START  = 3'd7;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int POS_W      = 14;
  // ADC sample width, matches the 12-bit level registers
  localparam int ADC_BITS   = 12;

  // controller to datapath commands
  typedef struct packed {
    logic       load;      // latch frame and op, per-op setup
    logic       sens_clr;  // reset per-frame accumulators, apply calibrate
    logic       sens_step; // process sensor at index
    logic       div_start; // start divider
    logic       finish;    // compute final position
  } lscp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_position;
    logic div_busy;
    logic last_sensor;
  } lscp_sts_t;

endpackage
`default_nettype wire

[rtl/lscp_stream_if.sv]
`default_nettype none
interface lscp_stream_if #(
  parameter int W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/line_sensor_calibrate_and_position.sv]
`default_nettype none
// Position op: one shared bit-serial divider does each sensor's rescale in turn, then
// the centroid divide, between accept and result. Other ops go from accept through
// a setup state to the result beat.
// Throughput: one item at a time; next accept the cycle after the result beat.
// Reset (rst, synchronous): config to defaults, calibration state cleared.
module line_sensor_calibrate_and_position #(
  parameter int SENSOR_COUNT = 8,
  parameter int SENSOR_PITCH = 1000
) (
  input  wire logic clk,
  input  wire logic rst,
  lscp_stream_if.sink   in_ch,
  lscp_stream_if.source out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [lscp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lscp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lscp_pkg::*;

  lscp_cmd_t cmd;
  lscp_sts_t sts;
  logic signed [POS_W-1:0] pos;
  logic lost, aol, aolr;
  logic [3:0] cnt;
  logic [7:0] mask;

  lscp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .cmd(cmd), .sts(sts)
  );

  lscp_datapath #(
    .SENSOR_COUNT(SENSOR_COUNT), .SENSOR_PITCH(SENSOR_PITCH)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .op_in(in_ch.data[2:0]),
    .samples_in(in_ch.data[3 +: SENSOR_COUNT*ADC_BITS]),
    .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
    .line_position(pos), .lost_line(lost), .all_on_line(aol),
    .all_on_line_rise(aolr), .calibrated_count(cnt), .calibrated_mask(mask)
  );

  assign out_ch.data = {mask, cnt, aolr, aol, lost, pos};
endmodule
`default_nettype wire

[rtl/lscp_divider.sv]
`default_nettype none
// Restoring divider, one quotient bit a cycle.
module lscp_divider #(
  parameter int W = 40
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              busy,
  output logic [W-1:0]      quotient
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic [W:0]    trial;

  assign trial = {rem, quotient[W-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!trial[W]) begin
        rem      <= trial[W-1:0];
        quotient <= {quotient[W-2:0], 1'b1};
      end else begin
        rem      <= {rem[W-2:0], quotient[W-1]};
        quotient <= {quotient[W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

[rtl/lscp_datapath.sv]
`default_nettype none
module lscp_datapath #(
  parameter int SENSOR_COUNT = 8,
  parameter int SENSOR_PITCH = 1000
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire lscp_pkg::lscp_cmd_t                       cmd,
  output lscp_pkg::lscp_sts_t                            sts,
  input  wire logic [2:0]                                op_in,
  input  wire logic [SENSOR_COUNT*lscp_pkg::ADC_BITS-1:0] samples_in,
  input  wire logic                                      cfg_we,
  input  wire logic [lscp_pkg::CFG_IDX_W-1:0]            cfg_idx,
  input  wire logic [lscp_pkg::CFG_DATA_W-1:0]           cfg_data,
  output logic signed [lscp_pkg::POS_W-1:0]              line_position,
  output logic                                           lost_line,
  output logic                                           all_on_line,
  output logic                                           all_on_line_rise,
  output logic [3:0]                                     calibrated_count,
  output logic [7:0]                                     calibrated_mask
);
  import lscp_pkg::*;

  localparam int IW    = $clog2(SENSOR_COUNT);
  localparam int FULL  = (SENSOR_COUNT + 1) * SENSOR_PITCH;
  localparam int HALF  = FULL / 2;
  localparam int WGT_W = $clog2(SENSOR_COUNT * SENSOR_PITCH + 1);
  localparam int SUM_W = 16 + $clog2(SENSOR_COUNT + 1);
  localparam int DIV_W = 16 + WGT_W + $clog2(SENSOR_COUNT + 1);
  localparam int CNT_W = $clog2(SENSOR_COUNT + 1);
  localparam logic [ADC_BITS-1:0] AMASK = '1;

  // configuration registers
  logic        follow_white, stop_inline, flag_inline;
  logic [11:0] min_span, preset_black, preset_white, white_start;
  logic [15:0] scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      follow_white <= 1'b0;
      stop_inline  <= 1'b0;
      flag_inline  <= 1'b0;
      min_span     <= 12'd500;
      scale        <= 16'd1000;
      preset_black <= 12'd3000;
      preset_white <= 12'd500;
      white_start  <= 12'd4095;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FOLLOW_WHITE: follow_white <= cfg_data[0];
        CFG_STOP_INLINE:  stop_inline  <= cfg_data[0];
        CFG_FLAG_INLINE:  flag_inline  <= cfg_data[0];
        CFG_MIN_SPAN:     min_span     <= cfg_data[11:0];
        CFG_SCALE:        scale        <= cfg_data;
        CFG_PRESET_BLACK: preset_black <= cfg_data[11:0];
        CFG_PRESET_WHITE: preset_white <= cfg_data[11:0];
        CFG_WHITE_START:  white_start  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // per-sensor state
  logic [ADC_BITS-1:0] black_lv [SENSOR_COUNT];
  logic [ADC_BITS-1:0] white_lv [SENSOR_COUNT];
  logic [ADC_BITS-1:0] thresh   [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] ok;
  logic calib_started, drift_right, inline_now, inline_before, last_lost;
  logic signed [POS_W-1:0] last_pos;

  // latched frame
  logic [2:0] op;
  logic [ADC_BITS-1:0] smp [SENSOR_COUNT];
  logic [IW-1:0] idx;

  // per-frame accumulators
  logic [CNT_W-1:0] blacks, whites;
  logic [SUM_W-1:0] sum;
  logic [DIV_W-1:0] wsum;
  logic [WGT_W-1:0] weight;

  // rescale divider (per sensor) and centroid divider share one unit
  logic             div_start_i;
  logic [DIV_W-1:0] div_a, div_b, div_q;
  logic             div_busy;
  logic             phase_centroid;
  logic             rs_pending;

  lscp_divider #(.W(DIV_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start_i), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quotient(div_q)
  );

  // current sensor clamp
  logic [ADC_BITS-1:0] s_cur, lo_cur, hi_cur, v_cl;
  logic                span_ok;
  always_comb begin
    s_cur  = smp[idx];
    lo_cur = white_lv[idx];
    hi_cur = black_lv[idx];
    span_ok = hi_cur > lo_cur;
    if (s_cur < lo_cur)      v_cl = lo_cur;
    else if (s_cur > hi_cur) v_cl = hi_cur;
    else                     v_cl = s_cur;
  end

  logic [ADC_BITS+15:0] num_r;
  logic [ADC_BITS-1:0]  den_r;
  logic                 prod_ok;

  always_comb begin
    div_start_i = 1'b0;
    div_a = '0;
    div_b = '0;
    if (cmd.div_start && !phase_centroid) begin
      div_start_i = 1'b1;
      div_a = DIV_W'(num_r);
      div_b = DIV_W'(den_r);
    end else if (cmd.div_start) begin
      div_start_i = 1'b1;
      div_a = wsum;
      div_b = DIV_W'(sum);
    end
  end

  // calibrate step: new levels per sensor
  logic [ADC_BITS-1:0] cb [SENSOR_COUNT];
  logic [ADC_BITS-1:0] cw [SENSOR_COUNT];
  always_comb begin
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      cb[i] = calib_started ? black_lv[i] : (preset_white[ADC_BITS-1:0] & AMASK);
      cw[i] = calib_started ? white_lv[i] : (white_start[ADC_BITS-1:0] & AMASK);
      if (smp[i] > cb[i]) cb[i] = smp[i];
      if (smp[i] < cw[i]) cw[i] = smp[i];
    end
  end

  logic [CNT_W-1:0] ok_cnt;
  always_comb begin
    ok_cnt = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) ok_cnt = ok_cnt + CNT_W'(ok[i]);
  end

  // final position math
  logic              no_line, inl_hit, lost_f;
  logic signed [31:0] pos_a, pos_b, pos_c;
  logic [15:0]       pos_mag, pos_q;
  logic [33:0]       pos_prod;
  always_comb begin
    inl_hit = (stop_inline || flag_inline) &&
              ((!follow_white && whites == '0) || (follow_white && blacks == '0));
    no_line = (!follow_white && blacks == '0) || (follow_white && whites == '0) ||
              (sum == '0);
    lost_f  = no_line || (inl_hit && stop_inline);
    if (no_line) pos_a = drift_right ? 32'(SENSOR_COUNT * SENSOR_PITCH) : 32'(SENSOR_PITCH);
    else         pos_a = 32'(div_q);
    if (follow_white) pos_a = 32'(FULL) - pos_a;
    pos_b = pos_a - 32'(HALF);
    // 20/100 scaling toward zero: magnitude times 52429 / 2^18
    pos_mag  = pos_b[31] ? 16'(-pos_b) : 16'(pos_b);
    pos_prod = 34'(pos_mag) * 34'(52429);
    pos_q    = pos_prod[33:18];
    if (lost_f) pos_b = pos_b[31] ? -32'(pos_q) : 32'(pos_q);
    pos_c = -pos_b;
    if (pos_c > 32'sd8191)  pos_c = 32'sd8191;
    if (pos_c < -32'sd8192) pos_c = -32'sd8192;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        black_lv[i] <= ADC_BITS'(12'd500);
        white_lv[i] <= {ADC_BITS{1'b1}} & AMASK;
        thresh[i]   <= '0;
      end
      ok <= '0;
      calib_started <= 1'b0;
      drift_right <= 1'b0;
      inline_now <= 1'b0;
      inline_before <= 1'b0;
      last_lost <= 1'b0;
      last_pos <= '0;
      phase_centroid <= 1'b0;
      rs_pending <= 1'b0;
    end else begin
      if (cmd.load) begin
        phase_centroid <= 1'b0;
        rs_pending <= 1'b0;
        unique case (op_in)
          OP_CALIB: ;
          OP_RESTART: begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
              black_lv[i] <= preset_white[ADC_BITS-1:0];
              white_lv[i] <= white_start[ADC_BITS-1:0];
              thresh[i]   <= '0;
            end
            ok <= '0;
            calib_started <= 1'b1;
          end
          OP_PRESET: begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
              black_lv[i] <= preset_black[ADC_BITS-1:0];
              white_lv[i] <= preset_white[ADC_BITS-1:0];
              thresh[i]   <= ADC_BITS'(({1'b0, preset_black[ADC_BITS-1:0]}
                              + {1'b0, preset_white[ADC_BITS-1:0]}) >> 1);
            end
            ok <= '0;
          end
          OP_CLRFLAG: inline_now <= 1'b0;
          default: ;
        endcase
      end
      // calibrate is applied on the cycle after load (frame is latched then)
      if (cmd.sens_clr && op == OP_CALIB) begin
        calib_started <= 1'b1;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
          black_lv[i] <= cb[i];
          white_lv[i] <= cw[i];
          thresh[i]   <= ADC_BITS'(({1'b0, cb[i]} + {1'b0, cw[i]}) >> 1);
          ok[i] <= (cb[i] > cw[i]) &&
                   ({4'd0, cb[i] - cw[i]} > {{(16-ADC_BITS){1'b0}}, min_span} >> 0);
        end
      end
      if (cmd.sens_step) rs_pending <= 1'b1;
      if (cmd.div_start && !phase_centroid) rs_pending <= 1'b0;
      if (cmd.finish) phase_centroid <= 1'b0;
      else if (cmd.div_start && sts.last_sensor && !phase_centroid && !rs_pending)
        phase_centroid <= 1'b1;
      if (cmd.finish && op == OP_POSITION) begin
        inline_before <= inline_now;
        inline_now    <= inl_hit;
        last_lost     <= lost_f;
        last_pos      <= POS_W'(pos_c);
        if (!lost_f) drift_right <= !(pos_a < 32'(HALF));
      end
    end
  end

  // frame latch, accumulators and rescale operands
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= op_in;
      for (int i = 0; i < SENSOR_COUNT; i++)
        smp[i] <= samples_in[i*ADC_BITS +: ADC_BITS];
    end
    if (cmd.sens_clr) begin
      idx <= '0;
      blacks <= '0;
      whites <= '0;
      sum <= '0;
      wsum <= '0;
      weight <= WGT_W'(SENSOR_PITCH);
    end
    if (cmd.sens_step) begin
      if (s_cur > thresh[idx]) blacks <= blacks + 1'b1;
      if (s_cur < thresh[idx]) whites <= whites + 1'b1;
      num_r   <= (ADC_BITS+16)'(v_cl - lo_cur) * (ADC_BITS+16)'(scale);
      den_r   <= hi_cur - lo_cur;
      prod_ok <= span_ok;
    end
    // accumulate a rescaled value once its division is done
    if (cmd.div_start && !phase_centroid && !rs_pending && !cmd.sens_step) begin
      sum  <= sum + (prod_ok ? SUM_W'(div_q) : '0);
      wsum <= wsum + (prod_ok ? DIV_W'(div_q[15:0]) * DIV_W'(weight) : '0);
      weight <= weight + WGT_W'(SENSOR_PITCH);
      if (!sts.last_sensor) idx <= idx + 1'b1;
    end
  end

  assign sts.is_position = (op == OP_POSITION);
  assign sts.div_busy    = div_busy;
  assign sts.last_sensor = (idx == IW'(SENSOR_COUNT - 1));

  assign line_position    = last_pos;
  assign lost_line        = last_lost;
  assign all_on_line      = inline_now;
  assign all_on_line_rise = inline_now && !inline_before;
  assign calibrated_count = 4'(ok_cnt);
  always_comb begin
    calibrated_mask = '0;
    for (int i = 0; i < SENSOR_COUNT && i < 8; i++) calibrated_mask[i] = ok[i];
  end

  // a rescale divide with zero span is masked off
  a_div_idle_on_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !div_busy) else $error("finish while divider busy");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !div_busy) else $error("load during divide");
  a_rise_flag: assert property (@(posedge clk) disable iff (rst)
    all_on_line_rise |-> all_on_line) else $error("rise without flag");
endmodule
`default_nettype wire

[rtl/lscp_ctrl.sv]
`default_nettype none
module lscp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lscp_pkg::lscp_cmd_t      cmd,
  input  wire lscp_pkg::lscp_sts_t sts
);
  import lscp_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_SETUP = 9'b0_0000_0010,
    S_STEP  = 9'b0_0000_0100,
    S_RDIV  = 9'b0_0000_1000,
    S_RWAIT = 9'b0_0001_0000,
    S_CWAIT = 9'b0_0010_0000,
    S_FIN   = 9'b0_0100_0000,
    S_OUT   = 9'b0_1000_0000,
    S_CDIV  = 9'b1_0000_0000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.sens_clr = 1'b1;
        state_next = sts.is_position ? S_STEP : S_OUT;
      end
      S_STEP: begin
        cmd.sens_step = 1'b1;
        state_next = S_RDIV;
      end
      S_RDIV: begin
        cmd.div_start = 1'b1;
        state_next = S_RWAIT;
      end
      S_RWAIT: if (!sts.div_busy) begin
        // accumulate result, then next sensor or centroid divide
        cmd.div_start = 1'b1;
        state_next = sts.last_sensor ? S_CDIV : S_STEP;
      end
      // start the centroid divide on the final sums
      S_CDIV: begin
        cmd.div_start = 1'b1;
        state_next = S_CWAIT;
      end
      S_CWAIT: if (!sts.div_busy) state_next = S_FIN;
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  a_out_after_work: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !out_valid) else $error("result too early");
  a_fin_to_out: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("finish not followed by result");
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
endmodule
`default_nettype wire

[test/lscp_stream_if.sv]
`default_nettype none
// Filler file kept for ordering: the stream interface itself lives in rtl/lscp_stream_if.sv.
// This file only provides a small package of stream widths for the test.
package lscp_test_pkg;
  localparam int IN_W  = 3 + 8 * 12;
  localparam int OUT_W = 14 + 1 + 1 + 1 + 4 + 8;
endpackage
`default_nettype wire

[test/line_sensor_calibrate_and_position_test.sv]
`default_nettype none
module line_sensor_calibrate_and_position_test;
  import lscp_pkg::*;
  import lscp_test_pkg::*;

  localparam int NS = 8;
  localparam int PITCH = 1000;
  localparam int FULL = (NS + 1) * PITCH;
  localparam int IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [7:0]         mask;
    logic [3:0]         cnt;
    logic               all_rise;
    logic               all_on;
    logic               lost;
    logic signed [13:0] pos;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  lscp_stream_if #(.W(IN_W))  in_ch ();
  lscp_stream_if #(.W(OUT_W)) out_ch ();

  line_sensor_calibrate_and_position DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // shadow copy of the block's configuration and calibration state
  logic        m_white, m_stop, m_flag;
  logic [11:0] m_span, m_pblack, m_pwhite, m_wstart;
  logic [15:0] m_scale;
  logic [11:0] m_black [NS];
  logic [11:0] m_wlev [NS];
  logic [11:0] m_thr [NS];
  logic        m_ok [NS];
  logic [3:0]  m_okcnt;
  logic        m_drift_r, m_inl_now, m_inl_before, m_started, m_lost;
  logic signed [13:0] m_pos;

  frame_result_t expected_frames [$];
  int  fails = 0;
  bit  gaps_on = 1'b1;
  int  hold_len = 0;
  bit  in_valid_high = 1'b0;

  task automatic restart_levels();
    for (int i = 0; i < NS; i++) begin
      m_black[i] = m_pwhite;
      m_wlev[i] = m_wstart;
      m_thr[i] = '0;
      m_ok[i] = 1'b0;
    end
    m_okcnt = '0;
    m_started = 1'b1;
  endtask

  task automatic shadow_reset();
    m_white = 0; m_stop = 0; m_flag = 0;
    m_span = 12'd500; m_scale = 16'd1000; m_pblack = 12'd3000;
    m_pwhite = 12'd500; m_wstart = 12'd4095;
    restart_levels();
    m_started = 0; m_drift_r = 0; m_inl_now = 0; m_inl_before = 0;
    m_pos = '0; m_lost = 0;
  endtask

  function automatic longint unsigned rescaled(longint unsigned v, longint unsigned lo,
                                               longint unsigned hi);
    if (hi <= lo) return 0;
    if (v < lo) v = lo;
    else if (v > hi) v = hi;
    return ((v - lo) * m_scale) / (hi - lo);
  endfunction

  // centroid position of one frame
  task automatic locate_line(logic [7:0][11:0] s);
    longint unsigned wsum, sum, v;
    int  whites, blacks;
    bit  lost;
    longint pos;
    wsum = 0; sum = 0; whites = 0; blacks = 0; lost = 0;
    m_inl_before = m_inl_now;
    m_inl_now = 0;
    for (int i = 0; i < NS; i++) begin
      if (s[i] > m_thr[i]) blacks++;
      if (s[i] < m_thr[i]) whites++;
      v = rescaled(s[i], m_wlev[i], m_black[i]);
      wsum += v * (i + 1) * PITCH;
      sum += v;
    end
    if ((m_stop || m_flag) && ((!m_white && whites == 0) || (m_white && blacks == 0))) begin
      m_inl_now = 1;
      if (m_stop) lost = 1;
    end
    if ((!m_white && blacks == 0) || (m_white && whites == 0) || sum == 0) begin
      lost = 1;
      pos = m_drift_r ? NS * PITCH : PITCH;
    end else begin
      pos = longint'(wsum / sum);
    end
    if (m_white) pos = FULL - pos;
    if (!lost) m_drift_r = (pos < FULL / 2) ? 1'b0 : 1'b1;
    pos = pos - FULL / 2;
    if (lost) pos = (20 * pos) / 100;
    pos = -pos;
    if (pos > 8191) pos = 8191;
    if (pos < -8192) pos = -8192;
    m_pos = pos[13:0];
    m_lost = lost;
  endtask

  task automatic predict_frame(logic [2:0] op, logic [7:0][11:0] s);
    frame_result_t r;
    case (op)
      OP_POSITION: begin
        locate_line(s);
      end
      OP_CALIB: begin
        if (!m_started) restart_levels();
        m_okcnt = 0;
        for (int i = 0; i < NS; i++) begin
          if (s[i] > m_black[i]) m_black[i] = s[i];
          if (s[i] < m_wlev[i]) m_wlev[i] = s[i];
          m_thr[i] = 12'((13'(m_black[i]) + 13'(m_wlev[i])) >> 1);
          m_ok[i] = (m_black[i] > m_wlev[i]) && (m_black[i] - m_wlev[i] > m_span);
          if (m_ok[i]) m_okcnt++;
        end
      end
      OP_RESTART: begin
        restart_levels();
      end
      OP_PRESET: begin
        for (int i = 0; i < NS; i++) begin
          m_black[i] = m_pblack;
          m_wlev[i] = m_pwhite;
          m_thr[i] = 12'((13'(m_pblack) + 13'(m_pwhite)) >> 1);
          m_ok[i] = 0;
        end
        m_okcnt = 0;
      end
      OP_CLRFLAG: begin
        m_inl_now = 0;
      end
      default: ;
    endcase
    r.pos = m_pos;
    r.lost = m_lost;
    r.all_on = m_inl_now;
    r.all_rise = m_inl_now && !m_inl_before;
    r.cnt = m_okcnt;
    for (int i = 0; i < NS; i++) r.mask[i] = m_ok[i];
    expected_frames.push_back(r);
  endtask

  // configuration write; the shadow copy changes with it
  task automatic write_reg(logic [2:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[15:0];
    case (idx)
      CFG_FOLLOW_WHITE: m_white = val[0];
      CFG_STOP_INLINE:  m_stop = val[0];
      CFG_FLAG_INLINE:  m_flag = val[0];
      CFG_MIN_SPAN:     m_span = val[11:0];
      CFG_SCALE:        m_scale = val[15:0];
      CFG_PRESET_BLACK: m_pblack = val[11:0];
      CFG_PRESET_WHITE: m_pwhite = val[11:0];
      CFG_WHITE_START:  m_wstart = val[11:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int draw_gap();
    return gaps_on ? $urandom_range(0, 10) : 0;
  endfunction

  // offer one frame beat and wait for it to be taken
  task automatic send_frame(logic [2:0] op, logic [7:0][11:0] s);
    logic [IN_W-1:0] d;
    int gap;
    // op in the low bits, sensor 0 right above it
    d = {s, op};
    gap = draw_gap();
    if (gap > 0) begin
      if (in_valid_high) in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= d;
    in_valid_high = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_frame(op, s);
  endtask

  // wait until every expected result is back, then let the block settle
  task automatic drain();
    if (in_valid_high) begin
      in_ch.valid <= 1'b0;
      in_valid_high = 1'b0;
    end
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [7:0][11:0] fill(logic [11:0] v);
    logic [7:0][11:0] s;
    for (int i = 0; i < NS; i++) s[i] = v;
    return s;
  endfunction

  function automatic logic [7:0][11:0] any_frame();
    logic [7:0][11:0] s;
    for (int i = 0; i < NS; i++) s[i] = 12'($urandom_range(0, 4095));
    return s;
  endfunction

  // line-like frame: a run of dark sensors on light floor, with noise; some frames all dark, all light or random
  function automatic logic [7:0][11:0] line_frame();
    logic [7:0][11:0] s;
    int c, w, k;
    c = $urandom_range(0, 7);
    w = $urandom_range(0, 3);
    k = $urandom_range(0, 9);
    for (int i = 0; i < NS; i++) begin
      if (k == 0) s[i] = 12'($urandom_range(0, 4095));
      else if (k == 1) s[i] = 12'($urandom_range(2800, 4095));
      else if (k == 2) s[i] = 12'($urandom_range(0, 600));
      else if (i >= c - w && i <= c + w) s[i] = 12'($urandom_range(2500, 4095));
      else s[i] = 12'($urandom_range(0, 900));
    end
    return s;
  endfunction

  // output checker
  initial begin
    frame_result_t got, want;
    int stall;
    @(negedge rst);
    forever begin
      stall = draw_gap();
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = out_ch.data;
      if (expected_frames.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        fails++;
      end else begin
        want = expected_frames.pop_front();
        if (got.pos !== want.pos) begin
          $error("line_position exp %0d got %0d", want.pos, got.pos); fails++;
        end
        if (got.lost !== want.lost) begin
          $error("lost_line exp %0d got %0d", want.lost, got.lost); fails++;
        end
        if (got.all_on !== want.all_on) begin
          $error("all_on_line exp %0d got %0d", want.all_on, got.all_on); fails++;
        end
        if (got.all_rise !== want.all_rise) begin
          $error("all_on_line_rise exp %0d got %0d", want.all_rise, got.all_rise); fails++;
        end
        if (got.cnt !== want.cnt) begin
          $error("calibrated_count exp %0d got %0d", want.cnt, got.cnt); fails++;
        end
        if (got.mask !== want.mask) begin
          $error("calibrated_mask exp %h got %h", want.mask, got.mask); fails++;
        end
      end
    end
  end

  // watchdog on stretches with no beat on either side
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic test_reset_state();
    send_frame(OP_POSITION, fill(12'd0));
    send_frame(OP_POSITION, fill(12'd4095));
    send_frame(3'd5, any_frame());
    send_frame(3'd6, fill(12'd0));
    send_frame(3'd7, fill(12'd4095));
  endtask

  task automatic test_calibration();
    // first calibrate step performs the implicit restart
    send_frame(OP_CALIB, fill(12'd0));
    send_frame(OP_CALIB, fill(12'd4095));
    send_frame(OP_POSITION, line_frame());
    send_frame(OP_POSITION, fill(12'd4095));
    send_frame(OP_POSITION, fill(12'd0));
    send_frame(OP_RESTART, fill(12'd0));
    send_frame(OP_POSITION, fill(12'd2000));
    drain();
    write_reg(CFG_MIN_SPAN, 0);
    send_frame(OP_CALIB, fill(12'd100));
    send_frame(OP_CALIB, fill(12'd101));
    drain();
    write_reg(CFG_MIN_SPAN, 4095);
  endtask

  task automatic test_preset_levels();
    send_frame(OP_PRESET, fill(12'd0));
    send_frame(OP_POSITION, line_frame());
    drain();
    // preset with black below white: zero rescale span everywhere
    write_reg(CFG_PRESET_BLACK, 0);
    write_reg(CFG_PRESET_WHITE, 4095);
    send_frame(OP_PRESET, fill(12'd0));
    send_frame(OP_POSITION, any_frame());
    drain();
    write_reg(CFG_PRESET_BLACK, 4095);
    write_reg(CFG_PRESET_WHITE, 0);
    write_reg(CFG_WHITE_START, 0);
    write_reg(CFG_SCALE, 65535);
    send_frame(OP_PRESET, fill(12'd0));
    send_frame(OP_POSITION, line_frame());
    send_frame(OP_POSITION, fill(12'd4095));
    drain();
    write_reg(CFG_SCALE, 1);
    send_frame(OP_POSITION, line_frame());
    drain();
    write_reg(CFG_SCALE, 1000);
  endtask

  task automatic test_all_inline();
    write_reg(CFG_FLAG_INLINE, 1);
    send_frame(OP_POSITION, fill(12'd4095));
    send_frame(OP_POSITION, fill(12'd4095));
    send_frame(OP_CLRFLAG, fill(12'd0));
    send_frame(OP_POSITION, line_frame());
    drain();
    write_reg(CFG_STOP_INLINE, 1);
    send_frame(OP_POSITION, fill(12'd4095));
    drain();
    write_reg(CFG_FOLLOW_WHITE, 1);
    send_frame(OP_POSITION, fill(12'd0));
    send_frame(OP_POSITION, line_frame());
    send_frame(OP_POSITION, fill(12'd4095));
    drain();
    write_reg(CFG_FOLLOW_WHITE, 0);
    write_reg(CFG_STOP_INLINE, 0);
    write_reg(CFG_FLAG_INLINE, 0);
  endtask

  task automatic random_config();
    write_reg(CFG_FOLLOW_WHITE, $urandom_range(0, 1));
    write_reg(CFG_STOP_INLINE, $urandom_range(0, 1));
    write_reg(CFG_FLAG_INLINE, $urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: write_reg(CFG_MIN_SPAN, 0);
      1: write_reg(CFG_MIN_SPAN, 4095);
      default: write_reg(CFG_MIN_SPAN, $urandom_range(0, 3000));
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(CFG_SCALE, 1);
      1: write_reg(CFG_SCALE, 65535);
      default: write_reg(CFG_SCALE, $urandom_range(1, 65535));
    endcase
    write_reg(CFG_PRESET_BLACK, $urandom_range(0, 4095));
    write_reg(CFG_PRESET_WHITE, $urandom_range(0, 4095));
    write_reg(CFG_WHITE_START, $urandom_range(0, 4095));
  endtask

  task automatic test_random();
    int k;
    for (int ph = 0; ph < 31; ph++) begin
      drain();
      random_config();
      gaps_on = (ph % 5 != 3);
      // usually restart and a calibrate sweep, else a preset, then a run of mostly positions
      if ($urandom_range(0, 4) != 0) begin
        send_frame(OP_RESTART, any_frame());
        repeat ($urandom_range(2, 6)) send_frame(OP_CALIB, line_frame());
      end else begin
        send_frame(OP_PRESET, any_frame());
      end
      repeat (50) begin
        k = $urandom_range(0, 19);
        if (k < 14) send_frame(OP_POSITION, line_frame());
        else if (k < 16) send_frame(OP_POSITION, any_frame());
        else if (k == 16) send_frame(OP_CALIB, any_frame());
        else if (k == 17) send_frame(OP_CLRFLAG, any_frame());
        else send_frame(3'($urandom_range(0, 7)), any_frame());
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    drain();
    gaps_on = 1'b0;
    hold_len = 3000;
    repeat (6) send_frame(OP_CALIB, any_frame());
    repeat (6) send_frame(OP_POSITION, line_frame());
    gaps_on = 1'b1;
  endtask

  initial begin
    shadow_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_calibration();
    test_preset_levels();
    test_all_inline();
    test_backpressure();
    test_random();
    drain();
    repeat (600) @(posedge clk);
    if (fails == 0 && expected_frames.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
